// ----- rtl/core/uvll_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvll_pkg
// Shared types, constants and the arctangent table for the unit vector to
// latitude and longitude converter.
// ----------------------------------------------------------------------------
package uvll_pkg;

  localparam int CordicSteps = 20;
  localparam int FracBits    = 20;
  localparam int AngW        = 31;
  localparam int OperW       = 36;
  localparam int RootW       = 32;

  localparam logic signed [AngW-1:0] Deg90  = AngW'(90) <<< FracBits;
  localparam logic signed [AngW-1:0] Deg180 = AngW'(180) <<< FracBits;

  typedef struct packed {
    logic signed [15:0] vec_x;
    logic signed [15:0] vec_y;
    logic signed [15:0] vec_z;
  } uvll_in_t;

  typedef struct packed {
    logic [6:0]  lat_degrees;
    logic [5:0]  lat_minutes;
    logic [12:0] lat_centiseconds;
    logic        lat_south;
    logic [7:0]  lon_degrees;
    logic [5:0]  lon_minutes;
    logic [12:0] lon_centiseconds;
    logic        lon_west;
    logic        at_pole;
  } uvll_out_t;

  typedef struct packed {
    logic signed [OperW-1:0] a;
    logic signed [OperW-1:0] b;
    logic signed [AngW-1:0]  acc;
    logic                    fixed;
  } cordic_t;

  typedef struct packed {
    logic [7:0]  deg;
    logic [5:0]  mins;
    logic [12:0] cs;
    logic        neg;
  } dms_t;

  function automatic logic signed [AngW-1:0] atan_q20(input logic [4:0] i);
    logic signed [AngW-1:0] r;
    begin
      case (i)
        5'd0:  r = 31'sd47185920;
        5'd1:  r = 31'sd27855475;
        5'd2:  r = 31'sd14718068;
        5'd3:  r = 31'sd7471121;
        5'd4:  r = 31'sd3750058;
        5'd5:  r = 31'sd1876857;
        5'd6:  r = 31'sd938658;
        5'd7:  r = 31'sd469357;
        5'd8:  r = 31'sd234682;
        5'd9:  r = 31'sd117342;
        5'd10: r = 31'sd58672;
        5'd11: r = 31'sd29336;
        5'd12: r = 31'sd14668;
        5'd13: r = 31'sd7334;
        5'd14: r = 31'sd3667;
        5'd15: r = 31'sd1833;
        5'd16: r = 31'sd917;
        5'd17: r = 31'sd458;
        5'd18: r = 31'sd229;
        5'd19: r = 31'sd115;
        5'd20: r = 31'sd57;
        5'd21: r = 31'sd29;
        5'd22: r = 31'sd14;
        5'd23: r = 31'sd7;
        5'd24: r = 31'sd4;
        5'd25: r = 31'sd2;
        5'd26: r = 31'sd1;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

  function automatic cordic_t cordic_init(input logic signed [16:0] a_in,
                                          input logic signed [16:0] b_in);
    cordic_t r;
    logic signed [OperW-1:0] a;
    logic signed [OperW-1:0] b;
    begin
      a = OperW'(a_in) <<< 16;
      b = OperW'(b_in) <<< 16;
      r.fixed = 1'b0;
      r.acc = '0;
      r.a = a;
      r.b = b;
      if (b_in == 17'sd0) begin
        r.fixed = 1'b1;
        r.acc = (a_in >= 0) ? '0 : -Deg180;
      end else if (a_in < 0) begin
        if (b_in >= 0) begin
          r.a = b;
          r.b = -a;
          r.acc = Deg90;
        end else begin
          r.a = -b;
          r.b = a;
          r.acc = -Deg90;
        end
      end
      return r;
    end
  endfunction

  function automatic cordic_t cordic_step(input cordic_t c, input logic [4:0] i);
    cordic_t r;
    logic signed [OperW-1:0] da;
    logic signed [OperW-1:0] db;
    begin
      r = c;
      da = c.b >>> i;
      db = c.a >>> i;
      if (!c.fixed) begin
        if (c.b >= 0) begin
          r.a = c.a + da;
          r.b = c.b - db;
          r.acc = c.acc + atan_q20(i);
        end else begin
          r.a = c.a - da;
          r.b = c.b + db;
          r.acc = c.acc - atan_q20(i);
        end
      end
      return r;
    end
  endfunction

endpackage

// ----- rtl/core/unit_vector_to_lat_lon_dms.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unit_vector_to_lat_lon_dms
// Converts a Q1.15 unit vector to latitude and longitude in degrees,
// minutes and centiseconds.
//
// One vector is transferred on the input channel (in_valid_i / in_ready_o)
// and one result on the output channel (out_valid_o / out_ready_i).
// The pipeline is an input register and 8 square root stages, a rotation
// register and 20 CORDIC stages, and 3 split stages: 33 registers in all.
// Throughput is one vector per cycle while the receiver takes results.
// When the receiver stalls, the whole pipeline holds and the input is not
// ready; nothing is lost or repeated, and the ready path is combinational.
// Reset clears all valid bits; the block is ready right after reset.
// A vector with x and z both zero sets at_pole and zeroes all longitude
// fields. Angle magnitudes are clamped to 90 and 180 degrees.
// ----------------------------------------------------------------------------
module unit_vector_to_lat_lon_dms (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  uvll_pkg::uvll_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output uvll_pkg::uvll_out_t out_data_o
);

  logic                             en;
  logic                             sq_vld;
  uvll_pkg::uvll_in_t               sq_itm;
  logic [15:0]                      sq_root;
  logic                             cd_vld;
  logic signed [uvll_pkg::AngW-1:0] lat;
  logic signed [uvll_pkg::AngW-1:0] lon;
  logic                             pole;
  logic [2:0]                       vld_q;
  logic [2:0]                       pole_q;
  uvll_pkg::dms_t                   lat_dms;
  uvll_pkg::dms_t                   lon_dms;

  assign en          = out_ready_i || !out_valid_o;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[2];

  uvll_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .item_i  (in_data_i),
    .valid_o (sq_vld),
    .item_o  (sq_itm),
    .root_o  (sq_root)
  );

  uvll_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_vld),
    .item_i  (sq_itm),
    .root_i  (sq_root),
    .valid_o (cd_vld),
    .lat_o   (lat),
    .lon_o   (lon),
    .pole_o  (pole)
  );

  uvll_dms u_lat (
    .clk_i   (clk_i),
    .en_i    (en),
    .ang_i   (lat),
    .limit_i (uvll_pkg::Deg90),
    .dms_o   (lat_dms)
  );

  uvll_dms u_lon (
    .clk_i   (clk_i),
    .en_i    (en),
    .ang_i   (lon),
    .limit_i (uvll_pkg::Deg180),
    .dms_o   (lon_dms)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[1:0], cd_vld};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pole_q <= {pole_q[1:0], pole};
    end
  end

  always_comb begin
    out_data_o.lat_degrees      = lat_dms.deg[6:0];
    out_data_o.lat_minutes      = lat_dms.mins;
    out_data_o.lat_centiseconds = lat_dms.cs;
    out_data_o.lat_south        = lat_dms.neg;
    out_data_o.at_pole          = pole_q[2];
    if (pole_q[2]) begin
      out_data_o.lon_degrees      = '0;
      out_data_o.lon_minutes      = '0;
      out_data_o.lon_centiseconds = '0;
      out_data_o.lon_west         = 1'b0;
    end else begin
      out_data_o.lon_degrees      = lon_dms.deg;
      out_data_o.lon_minutes      = lon_dms.mins;
      out_data_o.lon_centiseconds = lon_dms.cs;
      out_data_o.lon_west         = lon_dms.neg;
    end
  end

endmodule

// ----- rtl/core/uvll_sqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvll_sqrt
// Pipelined integer square root of 2^30 - y*y, two result bits per stage,
// with the input item carried alongside.
// ----------------------------------------------------------------------------
module uvll_sqrt (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  uvll_pkg::uvll_in_t item_i,
  output logic               valid_o,
  output uvll_pkg::uvll_in_t item_o,
  output logic [15:0]        root_o
);

  localparam int Stages = 8;

  logic [Stages:0]         vld_q;
  uvll_pkg::uvll_in_t      itm_q [Stages+1];
  logic [31:0]             rem_q [Stages+1];
  logic [31:0]             res_q [Stages+1];
  logic [31:0]             sq;

  assign sq = 32'(32'sd0 + $signed(item_i.vec_y) * $signed(item_i.vec_y));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      itm_q[0] <= item_i;
      rem_q[0] <= 32'h4000_0000 - sq;
      res_q[0] <= '0;
    end
  end

  for (genvar s = 0; s < Stages; s++) begin : g_st
    logic [31:0] rem_d;
    logic [31:0] res_d;
    logic [31:0] bit0;
    logic [31:0] bit1;
    always_comb begin
      rem_d = rem_q[s];
      res_d = res_q[s];
      bit0 = 32'h1 << (30 - 4 * s);
      bit1 = 32'h1 << (28 - 4 * s);
      if (rem_d >= res_d + bit0) begin
        rem_d = rem_d - (res_d + bit0);
        res_d = (res_d >> 1) + bit0;
      end else begin
        res_d = res_d >> 1;
      end
      if (rem_d >= res_d + bit1) begin
        rem_d = rem_d - (res_d + bit1);
        res_d = (res_d >> 1) + bit1;
      end else begin
        res_d = res_d >> 1;
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        itm_q[s+1] <= itm_q[s];
        rem_q[s+1] <= rem_d;
        res_q[s+1] <= res_d;
      end
    end
  end

  assign valid_o = vld_q[Stages];
  assign item_o  = itm_q[Stages];
  assign root_o  = res_q[Stages][15:0];

endmodule

// ----- rtl/core/uvll_cordic.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvll_cordic
// Two parallel CORDIC vectoring pipelines, one step per stage, giving the
// latitude and longitude angles in Q10.20 degrees.
// ----------------------------------------------------------------------------
module uvll_cordic (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  uvll_pkg::uvll_in_t              item_i,
  input  logic [15:0]                     root_i,
  output logic                            valid_o,
  output logic signed [uvll_pkg::AngW-1:0] lat_o,
  output logic signed [uvll_pkg::AngW-1:0] lon_o,
  output logic                            pole_o
);

  localparam int N = uvll_pkg::CordicSteps;

  logic [N:0]         vld_q;
  logic [N:0]         pole_q;
  uvll_pkg::cordic_t  lat_q [N+1];
  uvll_pkg::cordic_t  lon_q [N+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lat_q[0]  <= uvll_pkg::cordic_init($signed({1'b0, root_i}), 17'(item_i.vec_y));
      lon_q[0]  <= uvll_pkg::cordic_init(17'(item_i.vec_x), 17'(item_i.vec_z));
      pole_q[0] <= (item_i.vec_x == '0) && (item_i.vec_z == '0);
    end
  end

  for (genvar s = 0; s < N; s++) begin : g_st
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        lat_q[s+1]  <= uvll_pkg::cordic_step(lat_q[s], 5'(s));
        lon_q[s+1]  <= uvll_pkg::cordic_step(lon_q[s], 5'(s));
        pole_q[s+1] <= pole_q[s];
      end
    end
  end

  assign valid_o = vld_q[N];
  assign lat_o   = -lat_q[N].acc;
  assign lon_o   = lon_q[N].acc;
  assign pole_o  = pole_q[N];

endmodule

// ----- rtl/core/uvll_dms.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvll_dms
// Splits a Q10.20 angle into degrees, minutes and rounded centiseconds in
// three register stages, with the seconds and minutes carries passed upward.
// ----------------------------------------------------------------------------
module uvll_dms (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic signed [uvll_pkg::AngW-1:0] ang_i,
  input  logic signed [uvll_pkg::AngW-1:0] limit_i,
  output uvll_pkg::dms_t                   dms_o
);

  localparam int F = uvll_pkg::FracBits;

  logic [uvll_pkg::AngW-1:0] mag_d;
  logic [uvll_pkg::AngW-1:0] mag_q;
  logic                      neg_q1;
  logic                      neg_q2;
  logic [7:0]                deg_q2;
  logic [5:0]                min_q2;
  logic [F-1:0]              g_q2;
  logic [25:0]               f60;
  logic [32:0]               cs_full;
  logic [12:0]               cs;
  logic [6:0]                mins;
  logic [8:0]                deg;

  always_comb begin
    mag_d = (ang_i < 0) ? -ang_i : ang_i;
    if (mag_d > limit_i) begin
      mag_d = limit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q  <= mag_d;
      neg_q1 <= ang_i < 0;
    end
  end

  assign f60 = 26'(mag_q[F-1:0]) * 26'd60;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      deg_q2 <= mag_q[F+7:F];
      min_q2 <= f60[F+5:F];
      g_q2   <= f60[F-1:0];
      neg_q2 <= neg_q1;
    end
  end

  always_comb begin
    cs_full = (33'(g_q2) * 33'd6000 + (33'd1 << (F - 1))) >> F;
    cs   = cs_full[12:0];
    mins = {1'b0, min_q2};
    deg  = {1'b0, deg_q2};
    if (cs >= 13'd6000) begin
      cs = '0;
      mins = mins + 7'd1;
    end
    if (mins >= 7'd60) begin
      mins = '0;
      deg = deg + 9'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dms_o.deg  <= deg[7:0];
      dms_o.mins <= mins[5:0];
      dms_o.cs   <= cs;
      dms_o.neg  <= neg_q2;
    end
  end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Streams Q1.15 vectors through the latitude and longitude converter with
// random idling on both sides and checks every result against an in-bench
// CORDIC predictor, comparing all fields at once, in order.
// ----------------------------------------------------------------------------
module tb;
  import uvll_pkg::*;

  localparam int NumSteps = 20;
  localparam int FracW    = 20;
  localparam int NumRand  = 500;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  uvll_in_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  uvll_out_t out_data_o;

  uvll_in_t  vec_q[$];
  uvll_out_t dms_q[$];
  int        n_err = 0;
  int        n_done = 0;
  int        n_pole = 0;
  int        in_gap = 0;
  int        out_gap = 0;
  bit        hold_in = 1'b0;

  unit_vector_to_lat_lon_dms u_dut (.*);

  always #1 clk_i = ~clk_i;

  function automatic longint atan_deg(int i);
    longint tbl[27] = '{47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
      938658, 469357, 234682, 117342, 58672, 29336, 14668, 7334, 3667, 1833,
      917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1};
    return (i < 27) ? tbl[i] : 0;
  endfunction

  function automatic longint vec_angle(longint a, longint b);
    longint acc, t, da, db;
    acc = 0;
    if (b == 0) return (a >= 0) ? 0 : -(longint'(180) <<< FracW);
    a = a <<< 16;
    b = b <<< 16;
    if (a < 0) begin
      if (b >= 0) begin
        t = a; a = b; b = -t; acc = longint'(90) <<< FracW;
      end else begin
        t = a; a = -b; b = t; acc = -(longint'(90) <<< FracW);
      end
    end
    for (int i = 0; i < NumSteps; i++) begin
      da = b >>> i;
      db = a >>> i;
      if (b >= 0) begin
        a += da; b -= db; acc += atan_deg(i);
      end else begin
        a -= da; b += db; acc -= atan_deg(i);
      end
    end
    return acc;
  endfunction

  function automatic dms_t split_angle(longint ang, longint lim);
    dms_t   r;
    longint mag, deg, f, mins, g, cs;
    mag = (ang < 0) ? -ang : ang;
    if (mag > lim) mag = lim;
    deg = mag >> FracW;
    f = (mag & ((longint'(1) << FracW) - 1)) * 60;
    mins = f >> FracW;
    g = f & ((longint'(1) << FracW) - 1);
    cs = (g * 6000 + (longint'(1) << (FracW - 1))) >> FracW;
    if (cs >= 6000) begin
      cs = 0; mins++;
    end
    if (mins >= 60) begin
      mins = 0; deg++;
    end
    r.deg = deg[7:0];
    r.mins = mins[5:0];
    r.cs = cs[12:0];
    r.neg = ang < 0;
    return r;
  endfunction

  function automatic uvll_out_t predict_dms(uvll_in_t v);
    uvll_out_t r;
    dms_t      d;
    longint    x, y, z, rem, root, bitv;
    x = v.vec_x; y = v.vec_y; z = v.vec_z;
    rem = (longint'(1) << 30) - y * y;
    root = 0;
    bitv = longint'(1) << 40;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem -= root + bitv; root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    r = '0;
    d = split_angle(-vec_angle(root, y), longint'(90) <<< FracW);
    r.lat_degrees = d.deg[6:0];
    r.lat_minutes = d.mins;
    r.lat_centiseconds = d.cs;
    r.lat_south = d.neg;
    if (x == 0 && z == 0) begin
      r.at_pole = 1'b1;
    end else begin
      d = split_angle(vec_angle(x, z), longint'(180) <<< FracW);
      r.lon_degrees = d.deg;
      r.lon_minutes = d.mins;
      r.lon_centiseconds = d.cs;
      r.lon_west = d.neg;
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic uvll_in_t mk_vec(int x, int y, int z);
    uvll_in_t v;
    v.vec_x = 16'(x); v.vec_y = 16'(y); v.vec_z = 16'(z);
    return v;
  endfunction

  function automatic uvll_in_t unit_vec();
    real th, ph;
    th = ($urandom_range(0, 100000) / 100000.0 - 0.5) * 3.14159265;
    ph = ($urandom_range(0, 100000) / 100000.0 - 0.5) * 6.2831853;
    return mk_vec(int'(32767.0 * $cos(th) * $cos(ph)), int'(32767.0 * $sin(th)),
                  int'(32767.0 * $cos(th) * $sin(ph)));
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        dms_q.push_back(predict_dms(in_data_i));
      end
      if (!(in_valid_i && !in_ready_o)) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid_i <= 1'b0;
        end else if (!hold_in && vec_q.size() > 0) begin
          in_valid_i <= 1'b1;
          in_data_i <= vec_q.pop_front();
          in_gap <= pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (dms_q.size() == 0) begin
          $display("%0t: result with nothing expected, actual %p", $time, out_data_o);
          n_err++;
        end else begin
          uvll_out_t exp_r;
          exp_r = dms_q.pop_front();
          if (exp_r !== out_data_o) begin
            $display("%0t: expected %p actual %p", $time, exp_r, out_data_o);
            n_err++;
          end
          n_done++;
          if (out_data_o.at_pole) n_pole++;
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        out_gap <= pick_gap();
      end
    end
  end

  initial begin
    int sel;
    vec_q.push_back(mk_vec(32767, 0, 0));
    vec_q.push_back(mk_vec(-32768, 0, 0));
    vec_q.push_back(mk_vec(0, 0, 32767));
    vec_q.push_back(mk_vec(0, 0, -32768));
    vec_q.push_back(mk_vec(0, 32767, 0));
    vec_q.push_back(mk_vec(0, -32768, 0));
    vec_q.push_back(mk_vec(0, 0, 0));
    vec_q.push_back(mk_vec(-32768, -32768, -32768));
    vec_q.push_back(mk_vec(32767, 32767, 32767));
    vec_q.push_back(mk_vec(-32768, 1, 1));
    vec_q.push_back(mk_vec(-32768, -1, -1));
    vec_q.push_back(mk_vec(-1, 0, 0));
    vec_q.push_back(mk_vec(32767, -1, -1));
    vec_q.push_back(mk_vec(23170, 23170, 23170));
    vec_q.push_back(mk_vec(-23170, -23170, 23170));
    vec_q.push_back(mk_vec(1, 1, -32768));
    vec_q.push_back(mk_vec(32767, 16384, 1));
    for (int i = 0; i < NumRand; i++) begin
      sel = $urandom_range(0, 9);
      if (sel < 6) vec_q.push_back(unit_vec());
      else if (sel < 8) vec_q.push_back(uvll_in_t'($urandom));
      else vec_q.push_back(mk_vec(0, $urandom, 0));
      if (i == NumRand / 2) begin
        vec_q.push_back(mk_vec(0, 0, 0));
      end
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (vec_q.size() < NumRand / 2);
    @(posedge clk_i);
    hold_in <= 1'b1;
    wait (dms_q.size() == 0 && !in_valid_i);
    @(posedge clk_i);
    hold_in <= 1'b0;
    wait (vec_q.size() == 0);
    wait (!in_valid_i && dms_q.size() == 0);
    repeat (40) @(posedge clk_i);
    $display("Checked %0d results, %0d of them at a pole, across axes, extremes,",
             n_done, n_pole);
    $display("unit vectors and raw bit patterns with random idling on both sides.");
    if (n_err == 0 && dms_q.size() == 0) begin
      $display("unit_vector_to_lat_lon_dms: match");
    end else begin
      $display("unit_vector_to_lat_lon_dms: mismatch");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("unit_vector_to_lat_lon_dms: mismatch");
    $finish;
  end

endmodule

// ----- unit_vector_to_lat_lon_dms.f -----
rtl/core/uvll_pkg.sv
rtl/core/uvll_sqrt.sv
rtl/core/uvll_cordic.sv
rtl/core/uvll_dms.sv
rtl/core/unit_vector_to_lat_lon_dms.sv
sim/tb.sv
